>>> rtl/mqrr_pkg.sv
// Shared types, codes and defaults for the round-robin transmit scheduler.
// No dependencies; used by every module of the block.
package mqrr_pkg;

  localparam int DEF_NUM_SLOTS        = 8;
  localparam int DEF_BUFFERS_PER_SLOT = 16;
  localparam int DEF_MAX_PACKET_BYTES = 65507;

  // Input action codes
  typedef enum logic [2:0] {
    ACT_REGISTER   = 3'd0,
    ACT_UNREGISTER = 3'd1,
    ACT_SEND_REQ   = 3'd2,
    ACT_SEND_DONE  = 3'd3,
    ACT_SEND_REJ   = 3'd4,
    ACT_CLOSE      = 3'd5
  } action_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CLOSED     = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_NOT_REG    = 3'd3,
    ST_ALREADY    = 3'd4,
    ST_NO_BUFFER  = 3'd5,
    ST_QUEUE_FULL = 3'd6
  } status_t;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE, OP_REG, OP_UNREG, OP_SEND, OP_DONE, OP_REJ, OP_CLOSE
  } op_t;

  // Which part of an item a start attempt belongs to
  typedef enum logic [1:0] {
    PH_FIRST, PH_SECOND, PH_LAST
  } phase_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    SQ_IDLE, SQ_SCAN, SQ_READ, SQ_RET
  } seq_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  slot;
    logic [15:0] size;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        dispatch_valid;
    logic [2:0]  dispatch_slot;
    logic [3:0]  dispatch_buffer;
    logic [15:0] dispatch_size;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  slot;
    logic [15:0] size;
  } cmd_t;

endpackage

>>> rtl/multi_queue_round_robin_tx_scheduler_unit.sv
// Top level of the round-robin transmit scheduler: front queue plus back sequencer.
// Depends on mqrr_pkg, mqrr_front and mqrr_back.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | in_data  (action, slot, size)
//  out_    | out | out_valid/out_stall| out_data (status, dispatch fields)
//
// Register/unregister/close/reject/done-with-nothing results come straight from the
// idle state of the back end; a send request runs up to two slot scans (before and
// after queuing), each with a registered read of the queue memory per inspected slot,
// and a completed send runs one slot scan to start the next item.
// Reset (rst_n low, synchronous) clears all control state; no clearing pass.
// Two items queue in front while a result waits under out_stall.
module multi_queue_round_robin_tx_scheduler_unit #(
  parameter int NUM_SLOTS        = mqrr_pkg::DEF_NUM_SLOTS,
  parameter int BUFFERS_PER_SLOT = mqrr_pkg::DEF_BUFFERS_PER_SLOT,
  parameter int MAX_PACKET_BYTES = mqrr_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mqrr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mqrr_pkg::out_t out_data
);
  import mqrr_pkg::*;

  logic fr_valid, fr_pop;
  cmd_t fr_cmd;

  // Item intake and decode
  mqrr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .fr_valid, .fr_cmd, .fr_pop
  );

  // Scheduling engine
  mqrr_back #(
    .NUM_SLOTS(NUM_SLOTS),
    .BUFFERS_PER_SLOT(BUFFERS_PER_SLOT),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_back (
    .clk, .rst_n, .fr_valid, .fr_cmd, .fr_pop,
    .out_valid, .out_stall, .out_data
  );

endmodule

>>> rtl/mqrr_front.sv
// Front end: accepts items, decodes the action and holds them in a two-entry queue.
// Depends on mqrr_pkg.
module mqrr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mqrr_pkg::in_t  in_data,
  output logic           fr_valid,
  output mqrr_pkg::cmd_t fr_cmd,
  input  logic           fr_pop
);
  import mqrr_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       push;

  // Action decode
  always_comb begin
    dec.slot = in_data.slot;
    dec.size = in_data.size;
    unique case (in_data.action)
      ACT_REGISTER:   dec.op = OP_REG;
      ACT_UNREGISTER: dec.op = OP_UNREG;
      ACT_SEND_REQ:   dec.op = OP_SEND;
      ACT_SEND_DONE:  dec.op = OP_DONE;
      ACT_SEND_REJ:   dec.op = OP_REJ;
      ACT_CLOSE:      dec.op = OP_CLOSE;
      default:        dec.op = OP_NONE;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign fr_valid = (cnt_r != 2'd0);
  assign fr_cmd   = q_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (fr_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(fr_pop);
    end
  end

endmodule

>>> rtl/mqrr_back.sv
// Back end: slot state, per-slot queue memory, round-robin start sequencer, result register.
// Depends on mqrr_pkg.
module mqrr_back #(
  parameter int NUM_SLOTS        = mqrr_pkg::DEF_NUM_SLOTS,
  parameter int BUFFERS_PER_SLOT = mqrr_pkg::DEF_BUFFERS_PER_SLOT,
  parameter int MAX_PACKET_BYTES = mqrr_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fr_valid,
  input  mqrr_pkg::cmd_t fr_cmd,
  output logic           fr_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output mqrr_pkg::out_t out_data
);
  import mqrr_pkg::*;

  localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int BIW = (BUFFERS_PER_SLOT > 1) ? $clog2(BUFFERS_PER_SLOT) : 1;
  localparam int CW  = $clog2(BUFFERS_PER_SLOT + 1);
  localparam int PW  = CW + 1;
  localparam int KW  = $clog2(NUM_SLOTS + 1);
  localparam int NE  = NUM_SLOTS * BUFFERS_PER_SLOT;
  localparam int AW  = (NE > 1) ? $clog2(NE) : 1;
  localparam int EW  = BIW + 16;

  // Sequencer and global state
  seq_t              state_r, state_nxt;
  phase_t            phase_r;
  cmd_t              cmd_r;
  logic [KW-1:0]     k_r;
  logic [SIW-1:0]    ss_r;
  logic              closed_r, inflight_r, alive_r;
  logic [SIW-1:0]    rr_r;
  logic [SIW-1:0]    fslot_r;
  logic [BIW-1:0]    fbuf_r;
  logic [15:0]       fsize_r;
  logic              dv_r;
  logic [SIW-1:0]    dslot_r;
  logic [BIW-1:0]    dbuf_r;
  logic [15:0]       dsize_r;
  // Per-slot state
  logic [NUM_SLOTS-1:0] reg_r;
  logic [BIW-1:0]    nb_r   [NUM_SLOTS];
  logic [BIW-1:0]    head_r [NUM_SLOTS];
  logic [CW-1:0]     cnt_r  [NUM_SLOTS];
  logic [NE-1:0]     owned_r;
  // Queue memory
  logic [EW-1:0]     mem [NE];
  logic [EW-1:0]     rd_r;
  // Result register
  logic              out_valid_r;
  out_t              out_r;

  cmd_t              cmd;
  logic [SIW-1:0]    si;
  logic              vs;
  logic              found;
  logic [SIW-1:0]    fsel;
  logic [KW-1:0]     fnext;
  logic [SIW:0]      off;
  logic [AW-1:0]     rd_addr;
  logic [SIW-1:0]    eq_s;
  logic [PW-1:0]     eq_pos;
  logic [AW-1:0]     eq_addr;
  logic              eq_full;
  logic [AW-1:0]     nb_addr;
  logic [AW-1:0]     f_addr;
  logic [BIW-1:0]    rbuf;
  logic [AW-1:0]     r_addr;
  logic              enq_ok;
  logic              mem_we;
  logic [EW-1:0]     wr_data;
  logic              emit;
  out_t              out_nxt;
  logic              can_start;

  assign cmd       = (state_r == SQ_IDLE) ? fr_cmd : cmd_r;
  assign si        = SIW'(cmd.slot);
  assign vs        = ({4'd0, cmd.slot} < 7'(NUM_SLOTS));
  assign fr_pop    = (state_r == SQ_IDLE) && fr_valid && (!out_valid_r || !out_stall);
  assign can_start = !closed_r && !inflight_r;

  // Rotating search for the first registered slot with a non-empty queue
  always_comb begin
    found = 1'b0;
    fsel  = '0;
    fnext = '0;
    off   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      off = {1'b0, rr_r} + (SIW + 1)'(i);
      if (off >= (SIW + 1)'(NUM_SLOTS)) off = off - (SIW + 1)'(NUM_SLOTS);
      if (!found && KW'(i) >= k_r && reg_r[off[SIW-1:0]] &&
          cnt_r[off[SIW-1:0]] != '0) begin
        found = 1'b1;
        fsel  = off[SIW-1:0];
        fnext = KW'(i + 1);
      end
    end
  end

  assign rd_addr = AW'(fsel) * AW'(BUFFERS_PER_SLOT) + AW'(head_r[fsel]);

  // Tail position for an enqueue (request slot or re-queued flight)
  always_comb begin
    eq_s   = (state_r == SQ_RET) ? si : fslot_r;
    eq_pos = PW'(head_r[eq_s]) + PW'(cnt_r[eq_s]);
    if (eq_pos >= PW'(BUFFERS_PER_SLOT)) eq_pos = eq_pos - PW'(BUFFERS_PER_SLOT);
  end
  assign eq_addr = AW'(eq_s) * AW'(BUFFERS_PER_SLOT) + AW'(eq_pos);
  assign eq_full = (cnt_r[eq_s] >= CW'(BUFFERS_PER_SLOT));
  assign nb_addr = AW'(si) * AW'(BUFFERS_PER_SLOT) + AW'(nb_r[si]);
  assign f_addr  = AW'(fslot_r) * AW'(BUFFERS_PER_SLOT) + AW'(fbuf_r);
  assign rbuf    = rd_r[EW-1:16];
  assign r_addr  = AW'(ss_r) * AW'(BUFFERS_PER_SLOT) + AW'(rbuf);
  assign enq_ok  = vs && reg_r[si] && !owned_r[nb_addr] && !eq_full;

  // Next state, result and memory write
  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    mem_we    = 1'b0;
    wr_data   = {fbuf_r, fsize_r};
    out_nxt   = '0;
    unique case (state_r)
      SQ_IDLE: begin
        if (fr_pop) begin
          unique case (fr_cmd.op)
            OP_REG: begin
              emit = 1'b1;
              if (closed_r) out_nxt.status = ST_CLOSED;
              else if (!vs) out_nxt.status = ST_NOT_REG;
              else if (reg_r[si]) out_nxt.status = ST_ALREADY;
            end
            OP_UNREG: begin
              emit = 1'b1;
              if (!vs || !reg_r[si]) out_nxt.status = ST_NOT_REG;
            end
            OP_SEND: begin
              if (fr_cmd.size > 16'(MAX_PACKET_BYTES)) begin
                emit = 1'b1;
                out_nxt.status = ST_BAD_SIZE;
              end else if (closed_r) begin
                emit = 1'b1;
                out_nxt.status = ST_CLOSED;
              end else begin
                state_nxt = SQ_SCAN;
              end
            end
            OP_DONE: begin
              if (inflight_r) state_nxt = SQ_SCAN;
              else emit = 1'b1;
            end
            OP_REJ: begin
              emit   = 1'b1;
              mem_we = inflight_r && alive_r && !closed_r && !eq_full;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      SQ_SCAN: begin
        state_nxt = (can_start && found) ? SQ_READ : SQ_RET;
      end
      SQ_READ: begin
        state_nxt = owned_r[r_addr] ? SQ_SCAN : SQ_RET;
      end
      SQ_RET: begin
        out_nxt.dispatch_valid  = dv_r;
        out_nxt.dispatch_slot   = 3'(dslot_r);
        out_nxt.dispatch_buffer = 4'(dbuf_r);
        out_nxt.dispatch_size   = dsize_r;
        if (phase_r == PH_FIRST) begin
          if (!vs || !reg_r[si]) out_nxt.status = ST_NOT_REG;
          else if (owned_r[nb_addr]) out_nxt.status = ST_NO_BUFFER;
          else if (eq_full) out_nxt.status = ST_QUEUE_FULL;
          mem_we  = enq_ok;
          wr_data = {nb_r[si], cmd_r.size};
          if (enq_ok && !dv_r) state_nxt = SQ_SCAN;
          else begin
            emit = 1'b1;
            state_nxt = SQ_IDLE;
          end
        end else begin
          emit = 1'b1;
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= SQ_IDLE;
    else state_r <= state_nxt;
  end

  // Queue memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[eq_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
    if (emit) out_r <= out_nxt;
  end

  // Slot, flight and sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      k_r        <= '0;
      ss_r       <= '0;
      closed_r   <= 1'b0;
      inflight_r <= 1'b0;
      alive_r    <= 1'b0;
      rr_r       <= '0;
      fslot_r    <= '0;
      fbuf_r     <= '0;
      fsize_r    <= '0;
      dv_r       <= 1'b0;
      dslot_r    <= '0;
      dbuf_r     <= '0;
      dsize_r    <= '0;
      reg_r      <= '0;
      owned_r    <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        nb_r[s]   <= '0;
        head_r[s] <= '0;
        cnt_r[s]  <= '0;
      end
    end else begin
      unique case (state_r)
        SQ_IDLE: begin
          if (fr_pop) begin
            cmd_r   <= fr_cmd;
            k_r     <= '0;
            dv_r    <= 1'b0;
            dslot_r <= '0;
            dbuf_r  <= '0;
            dsize_r <= '0;
            unique case (fr_cmd.op)
              OP_REG: begin
                if (!closed_r && vs && !reg_r[si]) begin
                  reg_r[si]  <= 1'b1;
                  nb_r[si]   <= '0;
                  head_r[si] <= '0;
                  cnt_r[si]  <= '0;
                  for (int b = 0; b < BUFFERS_PER_SLOT; b++)
                    owned_r[AW'(si) * AW'(BUFFERS_PER_SLOT) + AW'(b)] <= 1'b0;
                end
              end
              OP_UNREG: begin
                if (vs && reg_r[si]) begin
                  reg_r[si] <= 1'b0;
                  cnt_r[si] <= '0;
                  if (inflight_r && fslot_r == si) alive_r <= 1'b0;
                end
              end
              OP_SEND: phase_r <= PH_FIRST;
              OP_DONE: begin
                if (inflight_r) begin
                  if (alive_r) owned_r[f_addr] <= 1'b0;
                  inflight_r <= 1'b0;
                  alive_r    <= 1'b0;
                  phase_r    <= PH_LAST;
                end
              end
              OP_REJ: begin
                if (inflight_r) begin
                  if (alive_r) begin
                    owned_r[f_addr] <= 1'b0;
                    if (!closed_r && !eq_full) cnt_r[fslot_r] <= cnt_r[fslot_r] + 1'b1;
                  end
                  inflight_r <= 1'b0;
                  alive_r    <= 1'b0;
                end
              end
              OP_CLOSE: closed_r <= 1'b1;
              default: ;
            endcase
          end
        end
        SQ_SCAN: begin
          ss_r <= fsel;
          k_r  <= fnext;
        end
        SQ_READ: begin
          // pop the head entry, then start it unless its buffer is owned
          head_r[ss_r] <= (head_r[ss_r] == BIW'(BUFFERS_PER_SLOT - 1)) ?
                          '0 : head_r[ss_r] + 1'b1;
          cnt_r[ss_r]  <= cnt_r[ss_r] - 1'b1;
          if (!owned_r[r_addr]) begin
            owned_r[r_addr] <= 1'b1;
            fslot_r    <= ss_r;
            fbuf_r     <= rbuf;
            fsize_r    <= rd_r[15:0];
            alive_r    <= 1'b1;
            inflight_r <= 1'b1;
            rr_r       <= (ss_r == SIW'(NUM_SLOTS - 1)) ? '0 : ss_r + 1'b1;
            dv_r       <= 1'b1;
            dslot_r    <= ss_r;
            dbuf_r     <= rbuf;
            dsize_r    <= rd_r[15:0];
          end
        end
        SQ_RET: begin
          if (phase_r == PH_FIRST && enq_ok) begin
            cnt_r[si] <= cnt_r[si] + 1'b1;
            nb_r[si]  <= (nb_r[si] == BIW'(BUFFERS_PER_SLOT - 1)) ? '0 : nb_r[si] + 1'b1;
            if (!dv_r) begin
              phase_r <= PH_SECOND;
              k_r     <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/mqrr_checker.sv
// Port-level checks for the transmit scheduler, bound to the top level.
// Depends on mqrr_pkg.
module mqrr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input mqrr_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input mqrr_pkg::out_t out_data
);
  import mqrr_pkg::*;

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed under stall");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // No result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // Idle dispatch fields are zero
  a_nodisp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dispatch_valid |->
      out_data.dispatch_slot == 3'd0 && out_data.dispatch_buffer == 4'd0 &&
      out_data.dispatch_size == 16'd0)
    else $error("stray dispatch fields");

  // A dispatch never comes with a register, size or closed refusal
  a_dispst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dispatch_valid |->
      out_data.status != ST_CLOSED && out_data.status != ST_BAD_SIZE &&
      out_data.status != ST_ALREADY && out_data.status != 3'd7)
    else $error("dispatch with bad status");

endmodule

bind multi_queue_round_robin_tx_scheduler_unit mqrr_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);
